@@ rtl/sldl_pkg.sv @@
// Shared types, constants and helpers for the stereo fractional delay line.
`default_nettype none

package sldl_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int DELAY_W    = 20;
   localparam int FRAC_W     = 8;
   localparam int DATA_W     = 2 * SAMPLE_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = 2;

   localparam logic [REG_SEL_W-1:0] REG_GAIN    = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_DELAY_L = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_DELAY_R = 2'd2;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = 48;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

   // acc / (6 * 2^24), round half up: bias by 3 * 2^24, shift by 25, divide by 3
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 48'sd50331648;
   localparam int ROUND_SH = 25;
   localparam int QUOT_W   = PROD_W - ROUND_SH;
   localparam logic signed [QUOT_W-1:0] QUOT_MAX = 23'sd98303;
   localparam logic signed [QUOT_W-1:0] QUOT_MIN = -23'sd98304;
   localparam int U_W = 18;
   localparam logic [U_W-1:0] QUOT_OFS = 18'd98304;

   // floor(u / 3) = (u * 174763) >> 19 for u < 2^19
   localparam logic [MUL_B_W-1:0] RECIP3 = 19'd174763;
   localparam int RECIP3_SH = 19;

   localparam logic signed [PROD_W-1:0] FB_BIAS = 48'sd16384;
   localparam int FB_SH = 15;
   localparam int FB_W  = SAMPLE_W + 1;

   localparam logic signed [SAMPLE_W+1:0] SAMPLE_MAX = 18'sd32767;
   localparam logic signed [SAMPLE_W+1:0] SAMPLE_MIN = -18'sd32768;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctrl_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SAMPLE_W+1:0] v);
      logic signed [SAMPLE_W+1:0] r;
      if (v > SAMPLE_MAX) begin
         r = SAMPLE_MAX;
      end else if (v < SAMPLE_MIN) begin
         r = SAMPLE_MIN;
      end else begin
         r = v;
      end
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/sldl_ram.sv @@
// Single-port-write, registered-read sample store holding both channels.
`default_nettype none

module sldl_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/sldl_mac.sv @@
// Shared signed multiplier with product register and accumulator.
`default_nettype none

module sldl_mac import sldl_pkg::*; (
   input  logic                       clock,
   input  mac_ctrl_type               ctrl,
   input  logic signed [MUL_A_W-1:0]  mul_a,
   input  logic signed [MUL_B_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]   prod,
   output logic signed [PROD_W-1:0]   acc
);

   logic signed [MUL_A_W+MUL_B_W-1:0] full_prod;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;

   assign full_prod = mul_a * mul_b;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.mul_en) begin
         prod_in = full_prod[PROD_W-1:0];
      end
      acc_in = acc_ff;
      if (ctrl.acc_load) begin
         acc_in = prod_ff;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

@@ rtl/stereo_lagrange_feedback_delay.sv @@
// Stereo feedback delay line with cubic Lagrange fractional read, top level.
//
// req_*: one stereo sample pair per transaction (tdata = in_left, in_right).
// rsp_*: one interpolated pair per input (tdata = out_left, out_right).
// csr_*: APB-style register port, gain at 0x0, left delay at 0x4, right at 0x8.
// Each channel runs through one shared multiplier: an optional delay
// reduction (DELAY_W + 1 - SPAN_W steps, none at the default depth), one
// position step and 16 calculation steps. rsp_tvalid is set in the same
// cycle that req_tready rises again after the input transaction.
// req_tready is low while a pair is processed. A finished pair waits in the
// output register; if the receiver stalls, the next pair is computed and
// then held until the register frees.
// Synchronous reset clears the configuration and sequencer registers, the write
// pointer and the output valid; store entries not yet written since reset read
// as zero by a fill marker, so no clearing pass is needed.
`default_nettype none

module stereo_lagrange_feedback_delay import sldl_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,     // [15:0] in_left, [31:16] in_right
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,     // [15:0] out_left, [31:16] out_right
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SPAN      = DEPTH * (2 ** FRAC_W);
   localparam int SPAN_W    = $clog2(SPAN + 1);
   localparam int RED_STEPS = (SPAN_W > DELAY_W) ? 0 : DELAY_W + 1 - SPAN_W;
   localparam int RED_W     = $clog2(RED_STEPS + 2);
   localparam int WORK_W    = ((SPAN_W > DELAY_W) ? SPAN_W : DELAY_W) + 1;
   localparam logic [WORK_W-1:0] SPAN_V   = WORK_W'(SPAN);
   localparam logic [WORK_W-1:0] SUB_INIT =
      SPAN_V << ((RED_STEPS == 0) ? 0 : RED_STEPS - 1);
   localparam logic [RED_W-1:0]  RED_LOAD  = RED_W'(RED_STEPS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam int PCE_W = 17;
   localparam int PAB_W = 20;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED  = 3'd1;
   localparam logic [2:0] S_POS  = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;

   localparam logic [3:0] ST_PCE = 4'd0;
   localparam logic [3:0] ST_PAB = 4'd1;
   localparam logic [3:0] ST_W0  = 4'd2;
   localparam logic [3:0] ST_M0  = 4'd3;
   localparam logic [3:0] ST_W1  = 4'd4;
   localparam logic [3:0] ST_M1  = 4'd5;
   localparam logic [3:0] ST_W2  = 4'd6;
   localparam logic [3:0] ST_M2  = 4'd7;
   localparam logic [3:0] ST_W3  = 4'd8;
   localparam logic [3:0] ST_M3  = 4'd9;
   localparam logic [3:0] ST_SUM = 4'd10;
   localparam logic [3:0] ST_RND = 4'd11;
   localparam logic [3:0] ST_DIV = 4'd12;
   localparam logic [3:0] ST_OUT = 4'd13;
   localparam logic [3:0] ST_FB  = 4'd14;
   localparam logic [3:0] ST_WR  = 4'd15;

   // configuration
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [DELAY_W-1:0] delay_l_ff, delay_l_in, delay_r_ff, delay_r_in;
   logic               csr_wr;
   logic [REG_SEL_W-1:0] csr_sel;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic [3:0]        step_ff, step_in;
   logic              chan_ff, chan_in;
   logic [RED_W-1:0]  red_ff, red_in;
   logic [WORK_W-1:0] d_ff, d_in, sub_ff, sub_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic              wrapped_ff, wrapped_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;

   // datapath
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic [ADDR_W-1:0]          tap_addr_ff, tap_addr_in;
   logic                       tap_ok_ff, tap_ok_in;
   logic signed [SAMPLE_W-1:0] in_l_ff, in_l_in, in_r_ff, in_r_in;
   logic signed [PCE_W-1:0]    pce_ff, pce_in;
   logic signed [PAB_W-1:0]    pab_ff, pab_in;
   logic [U_W-1:0]             u_ff, u_in;
   logic signed [SAMPLE_W-1:0] y_l_ff, y_l_in, y_r_ff, y_r_in;
   logic signed [SAMPLE_W-1:0] wd_l_ff, wd_l_in;
   logic [DATA_W-1:0]          rsp_tdata_ff, rsp_tdata_in;

   logic [WORK_W-1:0]          pos_raw, pos;
   logic [ADDR_W-1:0]          pos_n, first_tap;
   logic                       rd_en, wr_en;
   logic [DATA_W-1:0]          rd_data, wr_data;
   logic signed [SAMPLE_W-1:0] tap_s, in_s, y_s, y_new, wd;
   logic signed [11:0]         op_a, op_b, op_c, op_e, op_nb;
   logic signed [13:0]         op_3a, op_n3e;
   logic signed [PROD_W-1:0]   rsum, fb_full;
   logic signed [QUOT_W-1:0]   quot, quot_c;
   logic signed [FB_W-1:0]     fb;
   logic [GAIN_W-1:0]          gain_eff;
   mac_ctrl_type               mac_ctrl;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod, acc;

   sldl_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (tap_addr_ff),
      .rd_data (rd_data)
   );

   sldl_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod),
      .acc   (acc)
   );

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      gain_in    = gain_ff;
      delay_l_in = delay_l_ff;
      delay_r_in = delay_r_ff;
      if (csr_wr) begin
         case (csr_sel)
            REG_GAIN:    gain_in    = csr_pwdata[GAIN_W-1:0];
            REG_DELAY_L: delay_l_in = csr_pwdata[DELAY_W-1:0];
            REG_DELAY_R: delay_r_in = csr_pwdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_GAIN:    csr_prdata = CSR_DATA_W'(gain_ff);
         REG_DELAY_L: csr_prdata = CSR_DATA_W'(delay_l_ff);
         REG_DELAY_R: csr_prdata = CSR_DATA_W'(delay_r_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // read position and taps
   assign pos_raw   = WORK_W'({wp_ff, {FRAC_W{1'b0}}}) + SPAN_V - d_ff;
   assign pos       = (pos_raw >= SPAN_V) ? pos_raw - SPAN_V : pos_raw;
   assign pos_n     = pos[ADDR_W+FRAC_W-1:FRAC_W];
   assign first_tap = (pos_n == '0) ? LAST_ADDR : pos_n - 1'b1;

   assign tap_s = !tap_ok_ff ? '0 :
                  chan_ff ? rd_data[DATA_W-1:SAMPLE_W] : rd_data[SAMPLE_W-1:0];
   assign in_s  = chan_ff ? in_r_ff : in_l_ff;
   assign y_s   = chan_ff ? y_r_ff : y_l_ff;

   // Lagrange node factors: a = f+2s, b = f+s, c = f, e = f-s
   assign op_c   = {4'h0, frac_ff};
   assign op_b   = {4'h1, frac_ff};
   assign op_a   = {4'h2, frac_ff};
   assign op_e   = {4'hF, frac_ff};
   assign op_nb  = -op_b;
   assign op_3a  = 14'(op_a) + (14'(op_a) <<< 1);
   assign op_n3e = -(14'(op_e) + (14'(op_e) <<< 1));

   // rounding and saturation ahead of the divide by three
   assign rsum   = acc + ROUND_BIAS;
   assign quot   = rsum[PROD_W-1:ROUND_SH];
   assign quot_c = (quot > QUOT_MAX) ? QUOT_MAX : (quot < QUOT_MIN) ? QUOT_MIN : quot;
   assign y_new  = {~prod[RECIP3_SH+SAMPLE_W-1], prod[RECIP3_SH+SAMPLE_W-2:RECIP3_SH]};

   assign gain_eff = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
   assign fb_full  = prod + FB_BIAS;
   assign fb       = fb_full[FB_SH+FB_W-1:FB_SH];
   assign wd       = sat_sample((SAMPLE_W+2)'(in_s) + (SAMPLE_W+2)'(fb));

   always_comb begin
      mac_ctrl = '0;
      mul_a    = '0;
      mul_b    = '0;
      rd_en    = 1'b0;
      if (state_ff == S_CALC) begin
         case (step_ff)
            ST_PCE: begin
               mac_ctrl.mul_en = 1'b1;
               mul_a = MUL_A_W'(op_c);
               mul_b = MUL_B_W'(op_e);
            end
            ST_PAB: begin
               mac_ctrl.mul_en = 1'b1;
               mul_a = MUL_A_W'(op_a);
               mul_b = MUL_B_W'(op_b);
            end
            ST_W0: begin
               mac_ctrl.mul_en = 1'b1;
               rd_en = 1'b1;
               mul_a = MUL_A_W'(pce_ff);
               mul_b = MUL_B_W'(op_nb);
            end
            ST_W1: begin
               mac_ctrl.mul_en   = 1'b1;
               mac_ctrl.acc_load = 1'b1;
               rd_en = 1'b1;
               mul_a = MUL_A_W'(pce_ff);
               mul_b = MUL_B_W'(op_3a);
            end
            ST_W2: begin
               mac_ctrl.mul_en  = 1'b1;
               mac_ctrl.acc_add = 1'b1;
               rd_en = 1'b1;
               mul_a = MUL_A_W'(pab_ff);
               mul_b = MUL_B_W'(op_n3e);
            end
            ST_W3: begin
               mac_ctrl.mul_en  = 1'b1;
               mac_ctrl.acc_add = 1'b1;
               rd_en = 1'b1;
               mul_a = MUL_A_W'(pab_ff);
               mul_b = MUL_B_W'(op_c);
            end
            ST_M0, ST_M1, ST_M2, ST_M3: begin
               mac_ctrl.mul_en = 1'b1;
               mul_a = prod[MUL_A_W-1:0];
               mul_b = MUL_B_W'(tap_s);
            end
            ST_SUM: begin
               mac_ctrl.acc_add = 1'b1;
            end
            ST_DIV: begin
               mac_ctrl.mul_en = 1'b1;
               mul_a = MUL_A_W'(u_ff);
               mul_b = RECIP3;
            end
            ST_FB: begin
               mac_ctrl.mul_en = 1'b1;
               mul_a = MUL_A_W'(y_s);
               mul_b = MUL_B_W'(gain_eff);
            end
            default: ;
         endcase
      end
   end

   assign wr_en   = (state_ff == S_CALC) && (step_ff == ST_WR) && chan_ff;
   assign wr_data = {wd, wd_l_ff};

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      chan_in       = chan_ff;
      red_in        = red_ff;
      d_in          = d_ff;
      sub_in        = sub_ff;
      wp_in         = wp_ff;
      wrapped_in    = wrapped_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      frac_in       = frac_ff;
      tap_addr_in   = tap_addr_ff;
      tap_ok_in     = tap_ok_ff;
      in_l_in       = in_l_ff;
      in_r_in       = in_r_ff;
      pce_in        = pce_ff;
      pab_in        = pab_ff;
      u_in          = u_ff;
      y_l_in        = y_l_ff;
      y_r_in        = y_r_ff;
      wd_l_in       = wd_l_ff;

      if (rd_en) begin
         tap_ok_in   = wrapped_ff || (tap_addr_ff < wp_ff);
         tap_addr_in = (tap_addr_ff == LAST_ADDR) ? '0 : tap_addr_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               in_l_in  = req_tdata[SAMPLE_W-1:0];
               in_r_in  = req_tdata[DATA_W-1:SAMPLE_W];
               chan_in  = 1'b0;
               d_in     = WORK_W'(delay_l_ff);
               sub_in   = SUB_INIT;
               red_in   = RED_LOAD;
               state_in = (RED_STEPS == 0) ? S_POS : S_RED;
            end
         end
         S_RED: begin
            if (d_ff >= sub_ff) begin
               d_in = d_ff - sub_ff;
            end
            sub_in = sub_ff >> 1;
            red_in = red_ff - 1'b1;
            if (red_ff == RED_W'(1)) begin
               state_in = S_POS;
            end
         end
         S_POS: begin
            frac_in     = pos[FRAC_W-1:0];
            tap_addr_in = first_tap;
            step_in     = ST_PCE;
            state_in    = S_CALC;
         end
         S_CALC: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               ST_PAB: pce_in = prod[PCE_W-1:0];
               ST_W0:  pab_in = prod[PAB_W-1:0];
               ST_RND: u_in   = U_W'(quot_c) + QUOT_OFS;
               ST_OUT: begin
                  if (chan_ff) begin
                     y_r_in = y_new;
                  end else begin
                     y_l_in = y_new;
                  end
               end
               ST_WR: begin
                  if (!chan_ff) begin
                     wd_l_in  = wd;
                     chan_in  = 1'b1;
                     d_in     = WORK_W'(delay_r_ff);
                     sub_in   = SUB_INIT;
                     red_in   = RED_LOAD;
                     state_in = (RED_STEPS == 0) ? S_POS : S_RED;
                  end else begin
                     wp_in    = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
                     if (wp_ff == LAST_ADDR) begin
                        wrapped_in = 1'b1;
                     end
                     state_in = S_PUSH;
                  end
               end
               default: ;
            endcase
         end
         S_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {y_r_ff, y_l_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= '0;
         delay_l_ff    <= '0;
         delay_r_ff    <= '0;
         state_ff      <= S_IDLE;
         step_ff       <= ST_PCE;
         chan_ff       <= 1'b0;
         red_ff        <= '0;
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         gain_ff       <= gain_in;
         delay_l_ff    <= delay_l_in;
         delay_r_ff    <= delay_r_in;
         state_ff      <= state_in;
         step_ff       <= step_in;
         chan_ff       <= chan_in;
         red_ff        <= red_in;
         wp_ff         <= wp_in;
         wrapped_ff    <= wrapped_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff         <= d_in;
      sub_ff       <= sub_in;
      frac_ff      <= frac_in;
      tap_addr_ff  <= tap_addr_in;
      tap_ok_ff    <= tap_ok_in;
      in_l_ff      <= in_l_in;
      in_r_ff      <= in_r_in;
      pce_ff       <= pce_in;
      pab_ff       <= pab_in;
      u_ff         <= u_in;
      y_l_ff       <= y_l_in;
      y_r_ff       <= y_r_in;
      wd_l_ff      <= wd_l_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

@@ rtl/sldl_checker.sv @@
// Port-level checks for the stereo delay line, bound to the top level.
`default_nettype none

module sldl_checker import sldl_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [DATA_W-1:0]     rsp_tdata,
   input wire logic                  csr_pready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an accepted pair keeps the block busy for the following cycles
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("input taken again during processing");

   // a new result only follows a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without processing");

   // reset leaves the block idle with no result
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && req_tready && csr_pready)
      else $error("block not idle after reset");

endmodule

bind stereo_lagrange_feedback_delay sldl_checker u_sldl_checker (.*);

`default_nettype wire

@@ bench/stereo_delay_checker.sv @@
// Checker for the stereo delay line: tracks registers, predicts each output pair, compares.

module stereo_delay_checker import sldl_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,     // [15:0] in_left, [31:16] in_right
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DATA_W-1:0]     rsp_tdata,     // [15:0] out_left, [31:16] out_right
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam longint FRAC_SPAN = 256;
   localparam longint GAIN_UNIT = 32768;

   typedef struct packed {
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] left;
   } pair_type;

   pair_type                   expected_pairs[$];
   logic signed [SAMPLE_W-1:0] left_mem[DEPTH];
   logic signed [SAMPLE_W-1:0] right_mem[DEPTH];
   int unsigned                wr_ptr;
   logic [GAIN_W-1:0]          gain_reg;
   logic [DELAY_W-1:0]         delay_l_reg;
   logic [DELAY_W-1:0]         delay_r_reg;
   int                         errs;
   pair_type                   got;
   pair_type                   want;
   logic signed [SAMPLE_W-1:0] in_l;
   logic signed [SAMPLE_W-1:0] in_r;
   logic signed [SAMPLE_W-1:0] y_l;
   logic signed [SAMPLE_W-1:0] y_r;
   longint                     eff_gain;

   function automatic longint floor_div(input longint a, input longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clamp_q15(input longint v);
      longint r;
      if (v > 32767) begin
         r = 32767;
      end else if (v < -32768) begin
         r = -32768;
      end else begin
         r = v;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   // cubic Lagrange read at write pointer minus delay, taps at n-1 .. n+2
   function automatic logic signed [SAMPLE_W-1:0] lagrange_read(
      input bit from_right, input logic [DELAY_W-1:0] dly);
      longint span;
      longint pos;
      longint n;
      longint f;
      longint s;
      longint acc;
      longint den;
      longint idx;
      longint wt[4];
      logic signed [SAMPLE_W-1:0] tap;
      span = longint'(DEPTH) * FRAC_SPAN;
      s = FRAC_SPAN;
      pos = (longint'(wr_ptr) * FRAC_SPAN + span - (longint'(dly) % span)) % span;
      n = pos / FRAC_SPAN;
      f = pos % FRAC_SPAN;
      den = 6 * s * s * s;
      wt[0] = -((f + s) * f * (f - s));
      wt[1] = 3 * (f + 2 * s) * f * (f - s);
      wt[2] = -3 * (f + 2 * s) * (f + s) * (f - s);
      wt[3] = (f + 2 * s) * (f + s) * f;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
         idx = (n + k + DEPTH - 1) % DEPTH;
         tap = from_right ? right_mem[idx] : left_mem[idx];
         acc = acc + wt[k] * longint'(tap);
      end
      return clamp_q15(floor_div(acc + den / 2, den));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] feedback_write(
      input logic signed [SAMPLE_W-1:0] smp,
      input logic signed [SAMPLE_W-1:0] y,
      input longint g);
      longint fb;
      fb = floor_div(longint'(y) * g + GAIN_UNIT / 2, GAIN_UNIT);
      return clamp_q15(longint'(smp) + fb);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            left_mem[i] = '0;
            right_mem[i] = '0;
         end
         wr_ptr = 0;
         gain_reg = '0;
         delay_l_reg = '0;
         delay_r_reg = '0;
         expected_pairs.delete();
         errs = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_GAIN:    gain_reg = csr_pwdata[GAIN_W-1:0];
               REG_DELAY_L: delay_l_reg = csr_pwdata[DELAY_W-1:0];
               REG_DELAY_R: delay_r_reg = csr_pwdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pairs.size() == 0) begin
               $error("output transaction with nothing expected: %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_pairs.pop_front();
               if (got.left !== want.left) begin
                  $error("out_left expected %0d actual %0d",
                         $signed(want.left), $signed(got.left));
                  errs++;
               end
               if (got.right !== want.right) begin
                  $error("out_right expected %0d actual %0d",
                         $signed(want.right), $signed(got.right));
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            in_l = req_tdata[SAMPLE_W-1:0];
            in_r = req_tdata[DATA_W-1:SAMPLE_W];
            y_l = lagrange_read(1'b0, delay_l_reg);
            y_r = lagrange_read(1'b1, delay_r_reg);
            eff_gain = (gain_reg > GAIN_ONE) ? GAIN_UNIT : longint'(gain_reg);
            left_mem[wr_ptr] = feedback_write(in_l, y_l, eff_gain);
            right_mem[wr_ptr] = feedback_write(in_r, y_r, eff_gain);
            wr_ptr = (wr_ptr + 1) % DEPTH;
            want.left = y_l;
            want.right = y_r;
            expected_pairs.push_back(want);
         end
      end
      pending_count <= expected_pairs.size();
      mismatch_count <= errs;
   end

endmodule

@@ bench/stereo_lagrange_feedback_delay_test.sv @@
// Testbench top for the stereo delay line: clock, reset, stimulus and verdict.

module stereo_lagrange_feedback_delay_test;
   import sldl_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam logic [REG_SEL_W-1:0] REG_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;      // [15:0] in_left, [31:16] in_right
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;           // [15:0] out_left, [31:16] out_right
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int pending_count;
   int sent_total = 0;
   int stall_left = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   bit calm;

   stereo_lagrange_feedback_delay #(.DEPTH(STORE_DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   stereo_delay_checker #(.DEPTH(STORE_DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (reset || receiver_calm) begin
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 11);
      end
      rsp_tready <= (stall_left == 0);
   end

   task automatic push_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
      req_tdata <= {r, l};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_total++;
      if (!sender_calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_for_outputs();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(input logic [REG_SEL_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] value);
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] gain,
                                 input logic [CSR_DATA_W-1:0] dly_l,
                                 input logic [CSR_DATA_W-1:0] dly_r);
      wait_for_outputs();
      csr_write(REG_GAIN, gain);
      csr_write(REG_DELAY_L, dly_l);
      csr_write(REG_DELAY_R, dly_r);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         default: v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      logic [CSR_DATA_W-1:0] g;
      case ($urandom_range(0, 5))
         0:       g = '0;
         1:       g = CSR_DATA_W'(GAIN_ONE);
         2:       g = $urandom_range(0, 65535);
         default: g = $urandom_range(8192, 32768);
      endcase
      return g;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_delay();
      logic [CSR_DATA_W-1:0] d;
      int back;
      back = $urandom_range(1, 40);
      case ($urandom_range(0, 7))
         0:       d = '0;
         1:       d = $urandom_range(0, 1) ? 32'd1047552 : 32'hFFFFF;
         2:       d = $urandom_range(0, 32'hFFFFF);
         // long delay that lands on the oldest written entries
         3:       d = ((sent_total + STORE_DEPTH - back) % STORE_DEPTH) * 256
                      + $urandom_range(0, 255);
         default: d = $urandom_range(0, 40 * 256);
      endcase
      return d;
   endfunction

   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unity feedback, zero delay on the left, 3.5 samples on the right
      apply_settings(32'h8000, 32'h0, 32'h380);
      push_pair(16'sh7FFF, 16'sh8000);
      push_pair(16'sh8000, 16'sh7FFF);
      push_pair(16'sh0000, 16'sh0000);
      push_pair(-16'sd1, 16'sd1);
      push_pair(16'sd1, -16'sd1);
      push_pair(16'sh7FFF, 16'sh7FFF);
      push_pair(16'sh8000, 16'sh8000);
      push_pair(16'sd12345, -16'sd12345);
      push_pair(16'sh0000, 16'sh0000);
      push_pair(16'sh0000, 16'sh0000);

      // gain above one, alternating full scale to drive interpolation overshoot
      apply_settings(32'hFFFF, 32'h180, 32'h2FF);
      repeat (4) begin
         push_pair(16'sh7FFF, 16'sh8000);
         push_pair(16'sh8000, 16'sh7FFF);
      end

      // unused register, upper value bits dropped, maximum left delay and a long right delay
      wait_for_outputs();
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      apply_settings(32'h0001_4000, 32'hFFFF_FFFF, 32'hFFF0_0000 | 32'd1047552);
      push_pair(16'sh7FFF, 16'sh8000);
      push_pair(random_sample(), random_sample());
      push_pair(random_sample(), random_sample());
      push_pair(16'sh8000, 16'sh7FFF);

      for (int phase = 0; phase < 12; phase++) begin
         calm = (phase == 11) || ($urandom_range(0, 3) == 0);
         sender_calm <= calm;
         receiver_calm <= calm;
         apply_settings(pick_gain(), pick_delay(), pick_delay());
         repeat (70) push_pair(random_sample(), random_sample());
      end

      wait_for_outputs();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ stereo_lagrange_feedback_delay.f @@
rtl/sldl_pkg.sv
rtl/sldl_ram.sv
rtl/sldl_mac.sv
rtl/stereo_lagrange_feedback_delay.sv
rtl/sldl_checker.sv
bench/stereo_delay_checker.sv
bench/stereo_lagrange_feedback_delay_test.sv
